// ===== rtl/edrs_pkg.sv =====
// Package for the earliest-deadline ring scheduler: slot and transaction types,
// action and status codes, deadline arithmetic helpers.
// No dependencies; compiled first.
package edrs_pkg;

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_TICK     = 2'd1,
    ACT_DISPATCH = 2'd2,
    ACT_COMPLETE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_FULL         = 3'd1,
    ST_EMPTY        = 3'd2,
    ST_NOT_READY    = 3'd3,
    ST_BUSY         = 3'd4,
    ST_NONE_RUNNING = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_SCAN,
    S_SWAP_HEAD,
    S_SWAP_BEST,
    S_COMPLETE,
    S_DONE
  } state_e;

  localparam logic signed [15:0] DEADLINE_FLOOR = -16'sd30000;
  localparam logic signed [16:0] DEADLINE_TOP   = 17'sd32767;

  typedef struct packed {
    logic        [7:0]  id;
    logic signed [15:0] deadline;
    logic        [14:0] period;
  } slot_t;

  typedef struct packed {
    action_e            action;
    logic        [7:0]  proc_id;
    logic signed [15:0] deadline;
    logic        [14:0] period;
    logic               repeat_req;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic        [7:0]  chosen_id;
    logic signed [15:0] chosen_deadline;
    logic        [3:0]  occupancy;
  } out_item_t;

  // deadline + period, clamped at the positive limit
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] d,
                                                 input logic [14:0] p);
    logic signed [16:0] s;
    s = {d[15], d} + {2'b00, p};
    return (s > DEADLINE_TOP) ? DEADLINE_TOP[15:0] : s[15:0];
  endfunction

  // one tick, held at the floor
  function automatic logic signed [15:0] tick_dec(input logic signed [15:0] d);
    return (d > DEADLINE_FLOOR) ? d - 16'sd1 : d;
  endfunction

endpackage

// ===== rtl/edrs_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct per transaction.
// Depends on nothing; payload type supplied by the user (types from edrs_pkg).
interface edrs_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/edrs_slot_mem.sv =====
// Slot store of the scheduler: one write port, one read port, registered read.
// Depends on edrs_pkg (slot_t).
module edrs_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  edrs_pkg::slot_t  wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output edrs_pkg::slot_t  rdata_o
);
  import edrs_pkg::*;

  slot_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/earliest_deadline_ring_scheduler_unit.sv =====
// Earliest-deadline ring scheduler: top level.
// Depends on edrs_pkg, edrs_stream_if and edrs_slot_mem.
//
// Usage
//   in_i  : one transaction per command (add, tick, dispatch, complete) with
//           id, deadline, period and repeat flag.
//   out_o : exactly one result transaction per command: status, chosen id,
//           chosen deadline and ring occupancy after the command.
// Commands are handled one at a time. Tick and dispatch walk the ring through
// the single read port of the slot memory, one entry per cycle; dispatch then
// swaps the best entry with the head in S_SWAP_HEAD and S_SWAP_BEST through the
// single write port. A new command is taken only after the result is registered.
// The result sits in an output register, so the next command is accepted
// while the receiver stalls; a finished result waits in the last state only
// if the previous one has not yet been taken.
// Reset clears head, tail, the running flag and the output valid; the slot
// memory is not cleared, as only entries between head and tail are read.
module earliest_deadline_ring_scheduler_unit #(
  parameter int POOL_SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  edrs_stream_if.sink   in_i,
  edrs_stream_if.source out_o
);
  import edrs_pkg::*;

  localparam int IW = $clog2(POOL_SLOTS);
  localparam int CW = IW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SLOTS - 1);
  localparam logic [CW-1:0] SLOTS_C  = CW'(POOL_SLOTS);

  typedef logic [IW-1:0] idx_t;

  function automatic idx_t ring_next(input idx_t i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  // control state
  state_e    state_q, state_d;
  idx_t      head_q, head_d;
  idx_t      tail_q, tail_d;
  logic      running_q, running_d;
  logic      out_valid_q, out_valid_d;
  logic      first_q, first_d;

  // walk and result registers
  idx_t      ptr_q, ptr_d;          // next address to read
  idx_t      cur_q, cur_d;          // address of data now on the read port
  idx_t      best_idx_q, best_idx_d;
  slot_t     best_q, best_d;
  slot_t     head_word_q, head_word_d;
  logic      repeat_q, repeat_d;
  status_e   res_status_q, res_status_d;
  logic [7:0] res_id_q, res_id_d;
  logic signed [15:0] res_dl_q, res_dl_d;
  out_item_t out_data_q, out_data_d;

  // slot memory port
  logic      mem_we;
  idx_t      mem_waddr;
  slot_t     mem_wdata;
  logic      mem_re;
  idx_t      mem_raddr;
  slot_t     mem_rdata;

  logic      full, empty;
  logic [CW-1:0] count;
  logic [8:0]    count_ext;
  logic [3:0]    occ;
  slot_t     add_word, tick_word, readd_word;

  edrs_slot_mem #(
    .DEPTH (POOL_SLOTS),
    .AW    (IW)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign full  = (ring_next(tail_q) == head_q);
  assign empty = (head_q == tail_q);

  // ring occupancy, clamped to the 4-bit result field
  assign count     = {1'b0, tail_q} + ((tail_q < head_q) ? SLOTS_C : '0) - {1'b0, head_q};
  assign count_ext = 9'(count);
  assign occ       = (count_ext > 9'd15) ? 4'd15 : count_ext[3:0];

  always_comb begin
    add_word.id       = in_i.payload.proc_id;
    add_word.deadline = sat_add(in_i.payload.deadline, in_i.payload.period);
    add_word.period   = in_i.payload.period;

    tick_word          = mem_rdata;
    tick_word.deadline = tick_dec(mem_rdata.deadline);

    readd_word          = mem_rdata;
    readd_word.deadline = sat_add(mem_rdata.deadline, mem_rdata.period);
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    running_d    = running_q;
    out_valid_d  = out_valid_q;
    first_d      = first_q;
    ptr_d        = ptr_q;
    cur_d        = cur_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    head_word_d  = head_word_q;
    repeat_d     = repeat_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_dl_d     = res_dl_q;
    out_data_d   = out_data_q;

    mem_we    = 1'b0;
    mem_waddr = tail_q;
    mem_wdata = add_word;
    mem_re    = 1'b0;
    mem_raddr = ptr_q;

    // output register drains independently of the command sequencer
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          repeat_d     = in_i.payload.repeat_req;
          res_status_d = ST_OK;
          res_id_d     = '0;
          res_dl_d     = '0;
          state_d      = S_DONE;
          case (in_i.payload.action)
            ACT_ADD: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_q;
                mem_wdata = add_word;
                tail_d    = ring_next(tail_q);
              end
            end
            ACT_TICK: begin
              if (!empty) begin
                mem_re    = 1'b1;
                mem_raddr = head_q;
                cur_d     = head_q;
                ptr_d     = ring_next(head_q);
                state_d   = S_TICK;
              end
            end
            ACT_DISPATCH: begin
              if (running_q) begin
                res_status_d = ST_BUSY;
              end else if (empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_q;
                cur_d     = head_q;
                ptr_d     = ring_next(head_q);
                first_d   = 1'b1;
                state_d   = S_SCAN;
              end
            end
            ACT_COMPLETE: begin
              if (!running_q) begin
                res_status_d = ST_NONE_RUNNING;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_q;
                state_d   = S_COMPLETE;
              end
            end
            default: begin
              res_status_d = ST_OK;
            end
          endcase
        end
      end

      // read one entry ahead, write back the previous one ticked
      S_TICK: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q;
        mem_wdata = tick_word;
        if (ptr_q != tail_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q;
          cur_d     = ptr_q;
          ptr_d     = ring_next(ptr_q);
        end else begin
          state_d = S_DONE;
        end
      end

      // strict less-than keeps the entry nearest the head on a tie
      S_SCAN: begin
        first_d = 1'b0;
        if (first_q) begin
          head_word_d = mem_rdata;
        end
        if (first_q || (mem_rdata.deadline < best_q.deadline)) begin
          best_d     = mem_rdata;
          best_idx_d = cur_q;
        end
        if (ptr_q != tail_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q;
          cur_d     = ptr_q;
          ptr_d     = ring_next(ptr_q);
        end else begin
          state_d = S_SWAP_HEAD;
        end
      end

      S_SWAP_HEAD: begin
        mem_we    = 1'b1;
        mem_waddr = head_q;
        mem_wdata = best_q;
        state_d   = S_SWAP_BEST;
      end

      // best at head already: rewrites the same word
      S_SWAP_BEST: begin
        mem_we    = 1'b1;
        mem_waddr = best_idx_q;
        mem_wdata = head_word_q;
        res_dl_d  = best_q.deadline;
        if (best_q.deadline <= 16'sd0) begin
          running_d = 1'b1;
          res_id_d  = best_q.id;
        end else begin
          res_status_d = ST_NOT_READY;
        end
        state_d = S_DONE;
      end

      // head word on the read port; re-add checks fullness before retiring
      S_COMPLETE: begin
        if (repeat_q) begin
          if (full) begin
            res_status_d = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = tail_q;
            mem_wdata = readd_word;
            tail_d    = ring_next(tail_q);
          end
        end
        head_d    = ring_next(head_q);
        running_d = 1'b0;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d                = 1'b1;
          out_data_d.status          = res_status_q;
          out_data_d.chosen_id       = res_id_q;
          out_data_d.chosen_deadline = res_dl_q;
          out_data_d.occupancy       = occ;
          state_d                    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
      first_q     <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    cur_q        <= cur_d;
    best_idx_q   <= best_idx_d;
    best_q       <= best_d;
    head_word_q  <= head_word_d;
    repeat_q     <= repeat_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_dl_q     <= res_dl_d;
    out_data_q   <= out_data_d;
  end

endmodule

// ===== rtl/edrs_checker.sv =====
// Port-level checks for the scheduler top level, with the bind that attaches them.
// Depends on edrs_pkg and earliest_deadline_ring_scheduler_unit.
module edrs_checker #(
  parameter int POOL_SLOTS = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input edrs_pkg::out_item_t out_data_i
);
  import edrs_pkg::*;

  localparam int MAX_OCC = (POOL_SLOTS - 1 > 15) ? 15 : POOL_SLOTS - 1;

  logic       in_acc, out_acc;
  logic [1:0] pending_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // transactions taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pending_q <= 2'd1)
    else $error("command taken with work still in flight");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != 2'd0)
    else $error("result delivered without a command");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.occupancy <= 4'(MAX_OCC))
    else $error("occupancy beyond ring capacity");

  a_not_ready_dl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == ST_NOT_READY
      |-> out_data_i.chosen_deadline > 16'sd0 && out_data_i.chosen_id == 8'd0)
    else $error("not ready with a due deadline or an id");

endmodule

bind earliest_deadline_ring_scheduler_unit edrs_checker #(
  .POOL_SLOTS (POOL_SLOTS)
) u_edrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.payload)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the earliest-deadline ring scheduler: a ring model predicts
// every result, directed then random command transactions drive in_i, a random sink stalls out_o.
// Depends on edrs_pkg, edrs_stream_if and the scheduler top level.

module testbench;
  import edrs_pkg::*;

  // Ring model plus the queue of results still owed by the block.
  class sched_scoreboard;
    localparam int unsigned SLOTS = 16;

    logic        [7:0]  id_mem [SLOTS];
    logic signed [15:0] dl_mem [SLOTS];
    logic        [14:0] per_mem[SLOTS];
    int unsigned        head;
    int unsigned        tail;
    bit                 running;
    out_item_t          owed_results[$];
    int unsigned        fault_count;

    function new();
      head        = 0;
      tail        = 0;
      running     = 1'b0;
      fault_count = 0;
    endfunction

    function int unsigned count();
      return (tail + SLOTS - head) % SLOTS;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // store at the tail, deadline raised by the period and clamped at the top
    function status_e push_entry(logic [7:0] id, logic signed [15:0] dl, logic [14:0] per);
      int sum;
      if ((tail + 1) % SLOTS == head) return ST_FULL;
      sum = int'(dl) + int'(per);
      if (sum > 32767) sum = 32767;
      id_mem[tail]  = id;
      dl_mem[tail]  = 16'(sum);
      per_mem[tail] = per;
      tail          = (tail + 1) % SLOTS;
      return ST_OK;
    endfunction

    // one accepted command: update the ring and queue the result it owes
    function void note_command(in_item_t cmd);
      out_item_t          res;
      int unsigned        idx;
      int unsigned        best;
      logic        [7:0]  t_id;
      logic signed [15:0] t_dl;
      logic        [14:0] t_per;
      res.status          = ST_OK;
      res.chosen_id       = '0;
      res.chosen_deadline = '0;
      case (cmd.action)
        ACT_ADD: begin
          res.status = push_entry(cmd.proc_id, cmd.deadline, cmd.period);
        end
        ACT_TICK: begin
          // running head counts down as well; floor holds
          for (idx = head; idx != tail; idx = (idx + 1) % SLOTS)
            if (dl_mem[idx] > DEADLINE_FLOOR) dl_mem[idx] = dl_mem[idx] - 16'sd1;
        end
        ACT_DISPATCH: begin
          if (running) begin
            res.status = ST_BUSY;
          end else if (head == tail) begin
            res.status = ST_EMPTY;
          end else begin
            // strict compare: on a tie the entry nearest the head wins
            best = head;
            for (idx = (head + 1) % SLOTS; idx != tail; idx = (idx + 1) % SLOTS)
              if (dl_mem[idx] < dl_mem[best]) best = idx;
            t_id          = id_mem[best];
            t_dl          = dl_mem[best];
            t_per         = per_mem[best];
            id_mem[best]  = id_mem[head];
            dl_mem[best]  = dl_mem[head];
            per_mem[best] = per_mem[head];
            id_mem[head]  = t_id;
            dl_mem[head]  = t_dl;
            per_mem[head] = t_per;
            res.chosen_deadline = t_dl;
            if (t_dl <= 16'sd0) begin
              running       = 1'b1;
              res.chosen_id = t_id;
            end else begin
              res.status = ST_NOT_READY;
            end
          end
        end
        default: begin
          if (!running) begin
            res.status = ST_NONE_RUNNING;
          end else begin
            // re-add happens before the head retires, so a full ring refuses it
            if (cmd.repeat_req)
              res.status = push_entry(id_mem[head], dl_mem[head], per_mem[head]);
            head    = (head + 1) % SLOTS;
            running = 1'b0;
          end
        end
      endcase
      res.occupancy = 4'(count());
      owed_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result transaction: status %0d id %0d deadline %0d occ %0d",
                   got.status, got.chosen_id, got.chosen_deadline, got.occupancy);
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status || got.chosen_id !== want.chosen_id ||
          got.chosen_deadline !== want.chosen_deadline || got.occupancy !== want.occupancy)
      begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("result mismatch: expected status %0d id %0d deadline %0d occ %0d",
                   want.status, want.chosen_id, want.chosen_deadline, want.occupancy);
          $display("                 got      status %0d id %0d deadline %0d occ %0d",
                   got.status, got.chosen_id, got.chosen_deadline, got.occupancy);
        end
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  edrs_stream_if #(.T(in_item_t))  in_ch ();
  edrs_stream_if #(.T(out_item_t)) out_ch ();

  earliest_deadline_ring_scheduler_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sched_scoreboard sb = new();

  bit quiet_tail   = 1'b0;  // no idling on either side once set
  bit hold_off_req = 1'b0;  // asks the sink for one long stall

  always #5ns clk_i = ~clk_i;

  // Offer one command transaction; note it once the handshake completes.
  task automatic issue(action_e act, logic [7:0] id, logic signed [15:0] dl,
                       logic [14:0] per, logic rep);
    in_item_t cmd;
    cmd.action     = act;
    cmd.proc_id    = id;
    cmd.deadline   = dl;
    cmd.period     = per;
    cmd.repeat_req = rep;
    in_ch.valid   <= 1'b1;
    in_ch.payload <= cmd;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_command(cmd);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Results are checked at the edge where they are taken.
  always @(posedge clk_i) begin
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) sb.check_result(out_ch.payload);
  end

  // Sink: random runs of ready and stalls, one long hold on request.
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req  = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (quiet_tail || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned r;
    int unsigned add_w;
    int          d;
    int          p;
    int unsigned k;
    action_e     act;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-ring cases first
    issue(ACT_DISPATCH, 8'h00, 16'sd0, 15'd0, 1'b0);
    issue(ACT_COMPLETE, 8'h00, 16'sd0, 15'd0, 1'b1);
    issue(ACT_TICK,     8'h00, 16'sd0, 15'd0, 1'b0);
    // single future entry: dispatch refuses, entry stays at the head
    issue(ACT_ADD,      8'h07, 16'sd5, 15'd3, 1'b0);
    issue(ACT_DISPATCH, 8'h00, 16'sd0, 15'd0, 1'b0);
    // field extremes: top saturation, most negative, around the tick floor
    issue(ACT_ADD,      8'hFF, 16'sh7FFF, 15'h7FFF, 1'b0);
    issue(ACT_ADD,      8'h00, 16'sh8000, 15'd0, 1'b0);
    issue(ACT_ADD,      8'hAA, -16'sd29999, 15'd0, 1'b0);
    issue(ACT_ADD,      8'h55, -16'sd30000, 15'd0, 1'b0);
    issue(ACT_ADD,      8'h01, 16'sh8000, 15'd0, 1'b0);   // ties with id 0
    issue(ACT_TICK,     8'h00, 16'sd0, 15'd0, 1'b0);
    issue(ACT_DISPATCH, 8'h00, 16'sd0, 15'd0, 1'b0);
    issue(ACT_DISPATCH, 8'h00, 16'sd0, 15'd0, 1'b0);       // busy
    issue(ACT_COMPLETE, 8'h00, 16'sd0, 15'd0, 1'b1);       // re-add then retire
    issue(ACT_ADD,      8'h5A, -16'sd1, 15'h7FFF, 1'b0);
    // fill the ring, then one add too many
    k = 0;
    while (sb.count() < 15) begin
      issue(ACT_ADD, 8'(8'h10 + k), 16'sd100, 15'd7, 1'b0);
      k++;
    end
    issue(ACT_ADD,      8'h3C, 16'sd0, 15'd0, 1'b0);
    issue(ACT_TICK,     8'h00, 16'sd0, 15'd0, 1'b0);
    issue(ACT_DISPATCH, 8'h00, 16'sd0, 15'd0, 1'b0);
    issue(ACT_COMPLETE, 8'h00, 16'sd0, 15'd0, 1'b1);       // re-add refused: full
    issue(ACT_COMPLETE, 8'h00, 16'sd0, 15'd0, 1'b0);       // nothing running

    // Random: add weight drifts so the ring swings between near empty and full
    add_w = 30;
    for (n = 0; n < 700; n++) begin
      if (n % 64 == 0) add_w = $urandom_range(15, 45);
      if (n == 250) hold_off_req = 1'b1;
      if (n == 600) quiet_tail = 1'b1;
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 19))
        0, 1:    d = int'($urandom_range(0, 65535)) - 32768;
        2:       d = int'($urandom_range(0, 10)) - 30005;   // around the floor
        3:       d = 32767 - int'($urandom_range(0, 7));    // near the top
        default: d = int'($urandom_range(0, 80)) - 40;      // mostly due soon
      endcase
      p = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 32767))
                                      : int'($urandom_range(0, 30));
      if (r < add_w)                               act = ACT_ADD;
      else if (r < add_w + (100 - add_w) / 3)      act = ACT_TICK;
      else if (r < add_w + 2 * (100 - add_w) / 3)  act = ACT_DISPATCH;
      else                                         act = ACT_COMPLETE;
      issue(act, 8'($urandom), 16'(d), 15'(p), 1'($urandom));
    end
    in_ch.valid <= 1'b0;

    // drain, then allow for a stray late result
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/edrs_pkg.sv
rtl/edrs_stream_if.sv
rtl/edrs_slot_mem.sv
rtl/earliest_deadline_ring_scheduler_unit.sv
rtl/edrs_checker.sv
tb/testbench.sv
